[sv/ptq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ptq_pkg;
    localparam int MAX_TASKS_DEF = 16;
    localparam int TIME_W = 48;
    localparam int IVL_W  = 32;
    localparam int ID_W   = 4;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_REM  = 2'd2;
    localparam logic [1:0] MODE_RES  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_FREE = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [TIME_W-1:0] now;
        logic [ID_W-1:0]   task_id;
        logic [IVL_W-1:0]  interval;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  result_task;
        logic             fired;
        logic [IVL_W-1:0] wait_time;
        logic             queue_empty;
    } t_rsp;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [IVL_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W-IVL_W+1){1'b0}}, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction
endpackage
`default_nettype wire

[sv/ptq_cmd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface ptq_cmd_if import ptq_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/ptq_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface ptq_rsp_if import ptq_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/ptq_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// Two-entry command queue between the port and the engine.
module ptq_front import ptq_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    input  wire t_cmd i_data,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_data,
    input  wire  i_ready
);
    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (pop) r_rd <= ~r_rd;
        end
        if (push) r_q[r_rd ^ r_cnt[0]] <= i_data;
    end
endmodule
`default_nettype wire

[sv/ptq_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sorted cell chain: each cell holds one slot, ordered by due time.
// Remove closes a gap (shift up), insert opens one (shift down).
module ptq_engine import ptq_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    input  wire t_cmd i_data,
    output logic o_ready,
    output logic o_valid,
    output t_rsp o_data,
    input  wire  i_ready
);
    localparam int SW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001, S_INS = 3'b010, S_OUT = 3'b100
    } t_state;

    t_state             r_st, n_st;
    logic [SW-1:0]      r_ord [MAX_TASKS];
    logic [TIME_W-1:0]  r_due [MAX_TASKS];
    logic [IVL_W-1:0]   r_per [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_used;
    logic [CW-1:0]      r_cnt;
    logic [SW-1:0]      r_slot;
    t_rsp               r_rsp;

    // classification of the queued command
    logic          id_ok, full, tick_fire;
    logic [SW-1:0] id_s, free_s, head;
    logic          free_found;
    logic [TIME_W-1:0] hdue, diff;
    logic [MAX_TASKS-1:0] keep, le;
    logic          do_rem, do_ins;
    logic [SW-1:0] rem_s;
    logic [TIME_W-1:0] new_due;
    logic [IVL_W-1:0]  new_per;
    logic          take;

    assign id_s = SW'(i_data.task_id);
    assign id_ok = ({{(32-ID_W){1'b0}}, i_data.task_id} < 32'(MAX_TASKS)) && r_used[id_s];
    assign full = (r_cnt >= CW'(MAX_TASKS));
    assign head = r_ord[0];
    assign hdue = r_due[head];
    assign diff = hdue - i_data.now;
    assign tick_fire = (r_cnt != '0) && (hdue < i_data.now);

    always_comb begin
        free_found = 1'b0;
        free_s = '0;
        for (int k = MAX_TASKS - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_found = 1'b1;
                free_s = SW'(k);
            end
        end
    end

    assign o_ready = (r_st == S_IDLE);
    assign take = i_valid && o_ready;
    assign o_valid = (r_st == S_OUT);
    assign o_data = r_rsp;

    always_comb begin
        do_rem = 1'b0;
        rem_s = id_s;
        do_ins = 1'b0;
        new_due = sat_add(i_data.now, i_data.interval);
        new_per = i_data.interval;
        case (i_data.mode)
            MODE_TICK: begin
                do_rem = tick_fire;
                rem_s = head;
                do_ins = tick_fire;
                new_due = sat_add(hdue, r_per[head]);
                new_per = r_per[head];
            end
            MODE_ADD: begin
                do_ins = !full && free_found;
                rem_s = free_s;
            end
            MODE_REM: do_rem = id_ok;
            MODE_RES: begin
                do_rem = id_ok;
                do_ins = id_ok;
            end
            default: ;
        endcase
    end

    // removal: cells at and after the matching one take their successor
    always_comb begin
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < MAX_TASKS; k++) begin
            if (CW'(k) < r_cnt && r_ord[k] == rem_s) hit = 1'b1;
            keep[k] = !hit;
        end
    end

    // insertion compare against the slot in r_slot
    always_comb begin
        for (int k = 0; k < MAX_TASKS; k++)
            le[k] = (CW'(k) < r_cnt) && (r_due[r_ord[k]] <= r_due[r_slot]);
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (take) n_st = do_ins ? S_INS : S_OUT;
            S_INS:  n_st = S_OUT;
            S_OUT:  if (i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_used <= '0;
            r_cnt  <= '0;
        end else begin
            r_st <= n_st;
            if (take) begin
                if (do_rem) begin
                    for (int k = 0; k < MAX_TASKS - 1; k++)
                        if (!keep[k]) r_ord[k] <= r_ord[k+1];
                end
                r_cnt <= r_cnt - CW'(do_rem);
                if (i_data.mode == MODE_REM && id_ok) r_used[id_s] <= 1'b0;
                if (i_data.mode == MODE_ADD && do_ins) r_used[free_s] <= 1'b1;
                if (do_ins) begin
                    r_due[rem_s] <= new_due;
                    r_per[rem_s] <= new_per;
                end
                r_slot <= rem_s;
                r_rsp.status <= (i_data.mode == MODE_ADD && !do_ins) ? ST_FULL :
                                ((i_data.mode == MODE_REM || i_data.mode == MODE_RES)
                                 && !id_ok) ? ST_FREE : ST_OK;
                r_rsp.result_task <= ((i_data.mode == MODE_ADD && do_ins) ||
                                      (i_data.mode == MODE_TICK && tick_fire))
                                     ? ID_W'(rem_s) : '0;
                r_rsp.fired <= (i_data.mode == MODE_TICK) && tick_fire;
                r_rsp.wait_time <= '0;
                if (i_data.mode == MODE_TICK && !tick_fire)
                    r_rsp.wait_time <= (r_cnt == '0 || diff[TIME_W-1:IVL_W] != '0)
                                       ? {IVL_W{1'b1}} : diff[IVL_W-1:0];
                r_rsp.queue_empty <= ((r_cnt - CW'(do_rem)) == '0) && !do_ins;
            end else if (r_st == S_INS) begin
                // cells past the insert point shift down one
                for (int k = MAX_TASKS - 1; k >= 0; k--) begin
                    if (!le[k] && CW'(k) <= r_cnt) begin
                        if (k == 0 || le[k > 0 ? k-1 : 0]) r_ord[k] <= r_slot;
                        else r_ord[k] <= r_ord[k > 0 ? k-1 : 0];
                    end
                end
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end
endmodule
`default_nettype wire

[sv/periodic_task_timer_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake      payload
// cmd      in   valid/ready    mode, now, task_id, interval
// rsp      out  valid/ready    status, result_task, fired, wait_time, queue_empty
// Each transaction runs the cell-chain states IDLE, OUT (IDLE, INS, OUT with an insert),
// following the remove-then-insert shift of the sorted cells.
// A two-entry queue takes up to two commands while a response stalls.
// Synchronous active-low reset empties the table; timing state is undefined until written.
module periodic_task_timer_queue import ptq_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input wire i_clk,
    input wire i_rst_n,
    ptq_cmd_if.sink   i_cmd,
    ptq_rsp_if.source o_rsp
);
    logic q_valid, q_ready;
    t_cmd q_data;

    ptq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_cmd.valid), .i_data(i_cmd.data), .o_ready(i_cmd.ready),
        .o_valid(q_valid), .o_data(q_data), .i_ready(q_ready)
    );

    ptq_engine #(.MAX_TASKS(MAX_TASKS)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .i_data(q_data), .o_ready(q_ready),
        .o_valid(o_rsp.valid), .o_data(o_rsp.data), .i_ready(o_rsp.ready)
    );
endmodule
`default_nettype wire
